// ----- rtl/btcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btcr_pkg
// Shared types and constants for the bitmap text cursor renderer.
// ----------------------------------------------------------------------------
package btcr_pkg;

  // Glyph store geometry (address is glyph * height + row, modulo depth)
  localparam int StoreAw = 12;
  localparam int StoreDepth = 1 << StoreAw;

  // Config register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FG_COLOR      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BG_COLOR      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TAB_STOP      = 3'd4;

  // Config reset values
  localparam logic [31:0] FG_RESET     = 32'hD8D8_D8D8;
  localparam logic [31:0] BG_RESET     = 32'h0000_0000;
  localparam logic [12:0] WIDTH_RESET  = 13'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd768;
  localparam logic [8:0]  TAB_RESET    = 9'd64;

  // Input actions
  localparam logic ACT_RENDER = 1'b0;
  localparam logic ACT_FONT_WR = 1'b1;

  // Control characters
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_NL  = 8'h0A;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_EMIT,
    ST_ADV,
    ST_WRAP
  } state_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// ----- rtl/btcr_font_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btcr_font_mem
// 8-bit glyph store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btcr_font_mem
  import btcr_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [StoreAw-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [StoreAw-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [StoreDepth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/btcr_rem_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btcr_rem_unit
// Bit-serial restoring remainder: 16-bit dividend by 9-bit divisor,
// one quotient bit per cycle, done pulses when the remainder is final.
// ----------------------------------------------------------------------------
module btcr_rem_unit
  import btcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [8:0]  divisor,
  output rem_stat_t   stat,
  output logic [8:0]  rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [8:0]  dsr_r, dsr_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [9:0]  trial;

  // One restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[15]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // trial < 2 * divisor, so a single subtract restores it
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 9'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[8:0];
      end
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// ----- rtl/bitmap_text_cursor_renderer_core.sv -----
`timescale 1ns / 1ps
// Font write: ready again next cycle. NUL, newline: idle, wrap, then idle.
// Glyph: emit, advance and wrap states, backspace skips advance. Emit issues one
// row per cycle while out_stall is low, set by the single glyph store read port.
// Tab: waits in the tab state on the 16-step bit-serial remainder unit.
// Output register lets the next item in while the last row waits.
// Synchronous active-low reset clears cursor, config and control state.
// ----------------------------------------------------------------------------
// bitmap_text_cursor_renderer_core
// Text-mode character renderer: cursor, glyph store and row sequencer.
// ----------------------------------------------------------------------------
module bitmap_text_cursor_renderer_core
  import btcr_pkg::*;
#(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // Config port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_wdata,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_char_code,
  input  logic [11:0]        in_font_address,
  input  logic [7:0]         in_font_byte,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_row_x,
  output logic [15:0]        out_row_y,
  output logic [7:0]         out_pixel_bits,
  output logic [31:0]        out_fg_out,
  output logic [31:0]        out_bg_out,
  output logic               out_last_row
);

  localparam int KW = $clog2(GLYPH_HEIGHT + 1);
  localparam logic [KW-1:0] RowCnt  = KW'(GLYPH_HEIGHT);
  localparam logic [KW-1:0] LastRow = KW'(GLYPH_HEIGHT - 1);
  localparam logic [15:0] RowStep = 16'(GLYPH_HEIGHT);
  localparam logic [15:0] ColStep = 16'(GLYPH_WIDTH);
  localparam logic [7:0]  PixMask = 8'((16'hFF00 >> GLYPH_WIDTH) & 16'h00FF);
  localparam logic [8:0]  GlyphN  = 9'(GLYPH_COUNT);

  // Config registers
  logic [31:0] fg_r, bg_r;
  logic [12:0] sw_r, sh_r;
  logic [8:0]  tab_r;

  // Sequencer and cursor
  state_t        state_r, state_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [StoreAw-1:0] base_r, base_nxt;
  logic          blank_r, blank_nxt;
  logic [KW-1:0] iss_k_r, iss_k_nxt;
  logic          pend_r, pend_nxt;
  logic [KW-1:0] pend_k_r, pend_k_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_x_r, out_y_r;
  logic [7:0]    out_bits_r;
  logic          out_last_r;

  logic          in_xfer, is_render;
  logic          issue, out_load, emit_done, rem_start, mem_we;
  logic [8:0]    code_ext, glyph_sel;
  logic [StoreAw-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [15:0]   col_adv;
  rem_stat_t     rem_stat;
  logic [8:0]    rem_val;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign is_render = (in_action == ACT_RENDER);

  // Config writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r  <= FG_RESET;
      bg_r  <= BG_RESET;
      sw_r  <= WIDTH_RESET;
      sh_r  <= HEIGHT_RESET;
      tab_r <= TAB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG_COLOR:      fg_r  <= cfg_wdata;
        REG_BG_COLOR:      bg_r  <= cfg_wdata;
        REG_SCREEN_WIDTH:  sw_r  <= cfg_wdata[12:0];
        REG_SCREEN_HEIGHT: sh_r  <= cfg_wdata[12:0];
        REG_TAB_STOP:      tab_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Glyph base address: code mod count (code < 2 * count), times height
  assign code_ext  = {1'b0, in_char_code};
  assign glyph_sel = (code_ext >= GlyphN) ? (code_ext - GlyphN) : code_ext;
  assign rd_addr   = base_r + StoreAw'(iss_k_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_render) begin
          unique case (in_char_code)
            CHAR_NUL: state_nxt = ST_WRAP;
            CHAR_NL:  state_nxt = ST_WRAP;
            CHAR_TAB: state_nxt = (tab_r != '0) ? ST_TAB : ST_WRAP;
            default:  state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_TAB:  if (rem_stat.done) state_nxt = ST_WRAP;
      ST_EMIT: if (emit_done) state_nxt = blank_r ? ST_WRAP : ST_ADV;
      ST_ADV:  state_nxt = ST_WRAP;
      ST_WRAP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mem_we    = in_xfer && !is_render;
    rem_start = in_xfer && is_render && (in_char_code == CHAR_TAB) && (tab_r != '0);
    out_load  = pend_r && (!out_valid_r || !out_stall);
    issue     = (state_r == ST_EMIT) && (iss_k_r != RowCnt) && (!pend_r || out_load);
    emit_done = (state_r == ST_EMIT) && (iss_k_r == RowCnt) && !pend_r;
  end

  // Cursor and row pipeline
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    base_nxt   = base_r;
    blank_nxt  = blank_r;
    iss_k_nxt  = iss_k_r;
    pend_nxt   = pend_r;
    pend_k_nxt = pend_k_r;
    col_adv    = col_r + ColStep;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_render) begin
          base_nxt  = StoreAw'(glyph_sel * GLYPH_HEIGHT);
          blank_nxt = (in_char_code == CHAR_BS);
          iss_k_nxt = '0;
          if (in_char_code == CHAR_NL) begin
            row_nxt = row_r + RowStep;
            col_nxt = '0;
          end else if (in_char_code == CHAR_BS) begin
            // backspace clamps at the left edge
            col_nxt = (col_r >= ColStep) ? (col_r - ColStep) : '0;
          end
        end
      end
      ST_TAB: begin
        if (rem_stat.done) begin
          col_nxt = col_r + 16'(tab_r - rem_val);
        end
      end
      ST_ADV: begin
        if (col_adv >= {3'b000, sw_r}) begin
          row_nxt = row_r + RowStep;
          col_nxt = '0;
        end else begin
          col_nxt = col_adv;
        end
      end
      ST_WRAP: begin
        if (row_r >= {3'b000, sh_r}) begin
          row_nxt = '0;
        end
      end
      default: ;
    endcase

    if (issue) begin
      iss_k_nxt  = iss_k_r + KW'(1);
      pend_k_nxt = iss_k_r;
      pend_nxt   = 1'b1;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      iss_k_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      iss_k_r     <= iss_k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    blank_r  <= blank_nxt;
    pend_k_r <= pend_k_nxt;
    if (out_load) begin
      out_x_r    <= col_r;
      out_y_r    <= row_r + 16'(pend_k_r);
      out_bits_r <= blank_r ? 8'h00 : (rd_data & PixMask);
      out_last_r <= (pend_k_r == LastRow);
    end
  end

  btcr_font_mem u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_font_address),
    .wdata (in_font_byte),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  btcr_rem_unit u_rem_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (col_r),
    .divisor  (tab_r),
    .stat     (rem_stat),
    .rem      (rem_val)
  );

  assign out_valid      = out_valid_r;
  assign out_row_x      = out_x_r;
  assign out_row_y      = out_y_r;
  assign out_pixel_bits = out_bits_r;
  assign out_last_row   = out_last_r;
  assign out_fg_out     = fg_r;
  assign out_bg_out     = bg_r;

endmodule

// ----- rtl/btcr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btcr_checker
// Port-level checks for the renderer core, bound to the top level.
// ----------------------------------------------------------------------------
module btcr_checker
  import btcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_row_x,
  input logic [15:0] out_row_y,
  input logic [7:0]  out_pixel_bits,
  input logic        out_last_row
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload does not move
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_row_x) && $stable(out_row_y) &&
      $stable(out_pixel_bits) && $stable(out_last_row))
    else $error("result payload changed while stalled");

  // Font write leaves the input ready in the next cycle
  a_font_wr_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_FONT_WR) |=> !in_stall)
    else $error("font write did not return to ready");

  // NUL only runs the row wrap check, then ready again
  a_nul_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_RENDER) && (in_char_code == CHAR_NUL)
      |=> in_stall ##1 !in_stall)
    else $error("NUL transfer took the wrong number of cycles");

endmodule

bind bitmap_text_cursor_renderer_core btcr_checker u_btcr_checker (.*);
